// ----- sv/cpmm_pkg.sv -----
// ----------------------------------------------------------------------------
// cpmm_pkg
// shared types, pattern table and helpers for the caseless pattern matcher
// ----------------------------------------------------------------------------
package cpmm_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAT_NUM     = 8;
    localparam int PAT_MAX_LEN = 12;
    localparam int CAT_W       = 6;
    localparam int OUT_W       = 16;

    // pattern text, right-justified, first character in the highest used byte
    localparam logic [PAT_MAX_LEN*BYTE_W-1:0] PAT_TEXT [PAT_NUM] = '{
        "union select",
        "<script>",
        "../",
        "wget",
        "curl",
        "cmd=",
        ".env",
        "phpmyadmin"
    };

    localparam int PAT_LEN [PAT_NUM] = '{12, 8, 3, 4, 4, 4, 4, 10};

    localparam logic [CAT_W-1:0] CAT_SQLI      = 6'b000001;
    localparam logic [CAT_W-1:0] CAT_XSS       = 6'b000010;
    localparam logic [CAT_W-1:0] CAT_TRAVERSAL = 6'b000100;
    localparam logic [CAT_W-1:0] CAT_RECON     = 6'b001000;
    localparam logic [CAT_W-1:0] CAT_SENSITIVE = 6'b010000;
    localparam logic [CAT_W-1:0] CAT_ADMIN     = 6'b100000;

    localparam logic [CAT_W-1:0] PAT_CAT [PAT_NUM] = '{
        CAT_SQLI, CAT_XSS, CAT_TRAVERSAL, CAT_RECON,
        CAT_RECON, CAT_RECON, CAT_SENSITIVE, CAT_ADMIN
    };

    typedef struct packed {
        logic shift;
        logic clear;
    } cpmm_cell_ctrl_t;

    function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [CAT_W-1:0] cat_of(input logic [PAT_NUM-1:0] rules);
        logic [CAT_W-1:0] cats;
        cats = '0;
        for (int k = 0; k < PAT_NUM; k++)
        begin
            if (rules[k])
            begin
                cats = cats | PAT_CAT[k];
            end
        end
        return cats;
    endfunction

endpackage

// ----- sv/caseless_multi_pattern_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// caseless_multi_pattern_matcher_unit
// case-folding multi-pattern substring matcher over a byte stream
// result: registered, valid in the cycle after the last item of a string is taken
// throughput: one item per cycle, set by the one-byte shift, unless output stalls
// reset: window bytes, hit mask and output valid all clear asynchronously
// ----------------------------------------------------------------------------
module caseless_multi_pattern_matcher_unit
    import cpmm_pkg::*;
#(
    parameter int PATTERN_COUNT = 8,
    parameter int WINDOW_LENGTH = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // data_byte
    input  logic             s_axis_tlast,   // end_of_string
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // rule_hits, category_hits, any_hit, pad
);

    logic                            in_acc;
    cpmm_cell_ctrl_t                 cell_ctrl;
    logic [WINDOW_LENGTH*BYTE_W-1:0] wnd;
    logic [PAT_NUM-1:0]              match;
    logic [PAT_NUM-1:0]              hits_now;

    logic [PAT_NUM-1:0] sticky_reg;
    logic [PAT_NUM-1:0] sticky_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [OUT_W-1:0]   out_data_reg;
    logic [OUT_W-1:0]   out_data_next;

    assign s_axis_tready   = !out_valid_reg || m_axis_tready;
    assign in_acc          = s_axis_tvalid && s_axis_tready;
    assign cell_ctrl.shift = in_acc;
    assign cell_ctrl.clear = s_axis_tlast;

    // newest byte enters at the top of the window
    assign wnd[(WINDOW_LENGTH-1)*BYTE_W +: BYTE_W] = fold_lower(s_axis_tdata);

    generate
        for (genvar i = 0; i < WINDOW_LENGTH - 1; i++)
        begin : g_cell
            cpmm_cell u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .ctrl (cell_ctrl),
                .din  (wnd[(i+1)*BYTE_W +: BYTE_W]),
                .dout (wnd[i*BYTE_W +: BYTE_W])
            );
        end

        for (genvar k = 0; k < PAT_NUM; k++)
        begin : g_pat
            if (k < PATTERN_COUNT)
            begin : g_used
                cpmm_pattern #(
                    .WINDOW_LENGTH(WINDOW_LENGTH),
                    .K            (k)
                ) u_pat (
                    .wnd(wnd),
                    .hit(match[k])
                );
            end
            else
            begin : g_unused
                assign match[k] = 1'b0;
            end
        end
    endgenerate

    assign hits_now = sticky_reg | match;

    always_comb
    begin
        sticky_next    = sticky_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_acc)
        begin
            if (s_axis_tlast)
            begin
                sticky_next    = '0;
                out_valid_next = 1'b1;
                out_data_next  = {1'b0, (hits_now != '0), cat_of(hits_now), hits_now};
            end
            else
            begin
                sticky_next = hits_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tlast) |=> (sticky_reg == '0 && out_valid_reg))
        else $error("hit mask not cleared or result missing after last item");

    a_any_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[14] == (out_data_reg[7:0] != '0)))
        else $error("any_hit disagrees with rule_hits");

    a_cat_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[13:8] == cat_of(out_data_reg[7:0])))
        else $error("category_hits disagrees with rule_hits");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result is stalled");

endmodule

// ----- sv/cpmm_cell.sv -----
// ----------------------------------------------------------------------------
// cpmm_cell
// one byte of the window chain, takes its neighbor's byte on each item, or zero on the last item of a string
// ----------------------------------------------------------------------------
module cpmm_cell
    import cpmm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cpmm_cell_ctrl_t   ctrl,
    input  logic [BYTE_W-1:0] din,
    output logic [BYTE_W-1:0] dout
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = ctrl.clear ? '0 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign dout = byte_reg;

endmodule

// ----- sv/cpmm_pattern.sv -----
// ----------------------------------------------------------------------------
// cpmm_pattern
// compares the tail of the window against one fixed pattern
// ----------------------------------------------------------------------------
module cpmm_pattern
    import cpmm_pkg::*;
#(
    parameter int WINDOW_LENGTH = 12,
    parameter int K             = 0
)
(
    input  logic [WINDOW_LENGTH*BYTE_W-1:0] wnd,
    output logic                            hit
);

    localparam int LEN = PAT_LEN[K];

    generate
        if (LEN > 0 && LEN <= WINDOW_LENGTH)
        begin : g_cmp
            logic [LEN-1:0] eq;
            for (genvar j = 0; j < LEN; j++)
            begin : g_ch
                assign eq[j] = (wnd[(WINDOW_LENGTH-LEN+j)*BYTE_W +: BYTE_W]
                                == PAT_TEXT[K][(LEN-1-j)*BYTE_W +: BYTE_W]);
            end
            assign hit = &eq;
        end
        else
        begin : g_none
            assign hit = 1'b0;
        end
    endgenerate

endmodule
